/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

/* rtl/ssiq_pkg.sv */
// Types and constants of the sorted set block
package ssiq_pkg;

   localparam int VALUE_W = 32;
   localparam int SIZE_W  = 7;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE    = 3'b001,
      S_COMPARE = 3'b010,
      S_UPDATE  = 3'b100
   } state_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic compare;
      logic insert;
   } cell_ctrl_type;

endpackage

/* rtl/ssiq_req_if.sv */
// Request channel interface: operation and value
interface ssiq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [31:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

/* rtl/ssiq_rsp_if.sv */
// Response channel interface: found flag, set size and status
interface ssiq_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [6:0] set_size;
   logic [1:0] status;

   modport source (output valid, output found, output set_size, output status, input ready);
   modport sink   (input valid, input found, input set_size, input status, output ready);
endinterface

/* rtl/ssiq_cell.sv */
// One cell of the sorted chain: holds one entry and its compare flags
module ssiq_cell
   import ssiq_pkg::*;
#(
   parameter int CW    = 7,
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctrl_type             ctrl,
   input  logic signed [VALUE_W-1:0] value,
   input  logic [CW-1:0]             count,
   input  logic signed [VALUE_W-1:0] left_entry,
   input  logic                      left_gt,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      gt,
   output logic                      eq
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      gt_ff, gt_in;
   logic                      eq_ff, eq_in;
   logic                      occupied;
   logic                      at_end;

   assign occupied = count > CW'(INDEX);
   assign at_end   = count == CW'(INDEX);

   always_comb begin
      gt_in    = gt_ff;
      eq_in    = eq_ff;
      entry_in = entry_ff;
      if (ctrl.compare) begin
         gt_in = occupied && (entry_ff > value);
         eq_in = occupied && (entry_ff == value);
      end
      if (ctrl.insert) begin
         // shift up from the left neighbour, or take the new value at its place
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt_ff || at_end) begin
            entry_in = value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         gt_ff <= gt_in;
         eq_ff <= eq_in;
      end
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign gt    = gt_ff;
   assign eq    = eq_ff;

endmodule

/* rtl/sorted_set_insert_query.sv */
// Top level of the sorted set: sequencer, cell chain and response register
//
// Usage: requests arrive on req_channel (operation, value); each request
// yields exactly one response on rsp_channel (found, set_size, status).
// Operation clear empties the set, insert adds a value at its sorted place
// unless present (duplicate: status 1, full: status 2), query reports
// membership. Operation code 3 leaves the set alone and answers with status 0.
// Requests are taken one at a time through the three-step sequence accept,
// compare in every cell, then update the chain, in which the response is
// registered; the response register frees the request side while a
// response waits.
// If the receiver stalls, the update step holds until the waiting response
// is taken, so the next request may be accepted but not completed.
// Reset (synchronous, active high) empties the set and drops any pending
// response; entry contents are left as they are and are never read unfilled.
module sorted_set_insert_query
   import ssiq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   ssiq_req_if.sink    req_channel,
   ssiq_rsp_if.source  rsp_channel
);

`include "assert_macros.svh"

   localparam int CW = $clog2(CAPACITY + 1);

   state_type                 state_ff, state_in;
   logic [1:0]                op_ff, op_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]             count_ff, count_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [SIZE_W-1:0]         rsp_size_ff, rsp_size_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;

   cell_ctrl_type             ctrl;
   logic signed [VALUE_W-1:0] entry [CAPACITY];
   logic [CAPACITY-1:0]       gt;
   logic [CAPACITY-1:0]       eq;
   logic [CAPACITY-1:0]       occupied_mask;
   logic                      found;
   logic                      full;
   logic                      slot_free;
   logic                      do_update;
   logic [CW-1:0]             count_next;
   logic [CW+SIZE_W-1:0]      count_wide;

   // chain of cells, each fed by its left neighbour, the head cell by the request value
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry;
      logic                      left_gt;
      if (i == 0) begin : g_head
         assign left_entry = value_ff;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_entry = entry[i-1];
         assign left_gt    = gt[i-1];
      end
      ssiq_cell #(
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .value      (value_ff),
         .count      (count_ff),
         .left_entry (left_entry),
         .left_gt    (left_gt),
         .entry      (entry[i]),
         .gt         (gt[i]),
         .eq         (eq[i])
      );
   end

   assign found     = |eq;
   assign full      = count_ff == CW'(CAPACITY);
   assign slot_free = !rsp_valid_ff || rsp_channel.ready;
   assign do_update = (state_ff == S_UPDATE) && slot_free;

   // one bit per filled cell
   assign occupied_mask = ~({CAPACITY{1'b1}} << count_ff);

   assign req_channel.ready = state_ff == S_IDLE;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      count_next    = count_ff;
      ctrl.compare  = 1'b0;
      ctrl.insert   = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_channel.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            // hold the request until every cell has compared against it
            if (req_channel.valid) begin
               op_in    = req_channel.operation;
               value_in = req_channel.value;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = S_UPDATE;
         end
         S_UPDATE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_status_in = ST_DONE;
               case (op_ff)
                  OP_CLEAR: begin
                     count_next = '0;
                  end
                  OP_INSERT: begin
                     rsp_found_in = found;
                     if (found) begin
                        rsp_status_in = ST_DUP;
                     end else if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        // advance the entries above the insertion point
                        ctrl.insert = 1'b1;
                        count_next  = count_ff + CW'(1);
                     end
                  end
                  OP_QUERY: begin
                     rsp_found_in = found;
                  end
                  default: begin
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      count_in    = count_next;
      count_wide  = {{SIZE_W{1'b0}}, count_next};
      rsp_size_in = do_update ? count_wide[SIZE_W-1:0] : rsp_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_channel.valid    = rsp_valid_ff;
   assign rsp_channel.found    = rsp_found_ff;
   assign rsp_channel.set_size = rsp_size_ff;
   assign rsp_channel.status   = rsp_status_ff;

   // the count never passes the capacity
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY))
   // over the filled cells the insert flags form a thermometer
   `ASSERT_IMPL(a_sorted_flags, clock, reset, state_ff == S_UPDATE,
                ((gt << 1) & ~gt & occupied_mask) == '0)
   // a full drop only happens with the set at capacity
   `ASSERT_IMPL(a_full_drop, clock, reset,
                rsp_valid_ff && (rsp_status_ff == ST_FULL), full)
   // a duplicate answer always reports the value as found
   `ASSERT_IMPL(a_dup_found, clock, reset,
                rsp_valid_ff && (rsp_status_ff == ST_DUP), rsp_found_ff)

endmodule

/* verif/ssiq_checker.sv */
// Checker for the sorted set: mirrors the set, predicts each response and compares it
module ssiq_checker
   import ssiq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic  clock,
   input  logic  reset,
   ssiq_req_if   req,
   ssiq_rsp_if   rsp,
   output int    mismatches,
   output int    awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              found;
      logic [SIZE_W-1:0] set_size;
      logic [1:0]        status;
   } set_answer_type;

   // mirror of the set, kept ascending in signed order
   logic signed [VALUE_W-1:0] members[$];
   set_answer_type            answers_due[$];
   int                        miss_count = 0;

   function automatic logic holds_value(input logic signed [VALUE_W-1:0] val);
      foreach (members[i]) begin
         if (members[i] == val) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic set_answer_type apply_request(input logic [1:0] op,
                                                    input logic signed [VALUE_W-1:0] val);
      set_answer_type ans;
      int             pos;
      ans = '0;
      pos = 0;
      case (op)
         OP_CLEAR: members.delete();
         OP_INSERT: begin
            ans.found = holds_value(val);
            if (ans.found)
               ans.status = ST_DUP;
            else if (members.size() >= CAPACITY)
               ans.status = ST_FULL;
            else begin
               while (pos < members.size() && members[pos] < val) pos++;
               members.insert(pos, val);
            end
         end
         OP_QUERY: ans.found = holds_value(val);
         default: ;
      endcase
      ans.set_size = SIZE_W'(members.size());
      return ans;
   endfunction

   always @(posedge clock) begin
      set_answer_type due;
      set_answer_type seen;
      if (reset) begin
         members.delete();
         answers_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            seen = '{found: rsp.found, set_size: rsp.set_size, status: rsp.status};
            if (answers_due.size() == 0) begin
               miss_count++;
               if (miss_count <= 10)
                  $display("unexpected response: found=%0d size=%0d status=%0d",
                           seen.found, seen.set_size, seen.status);
            end else begin
               due = answers_due.pop_front();
               if (seen.found !== due.found || seen.set_size !== due.set_size ||
                   seen.status !== due.status) begin
                  miss_count++;
                  if (miss_count <= 10)
                     $display("mismatch: expected found=%0d size=%0d status=%0d, %s%0d %s%0d %s%0d",
                              due.found, due.set_size, due.status,
                              "got found=", seen.found, "size=", seen.set_size,
                              "status=", seen.status);
               end
            end
         end
         if (req.valid && req.ready)
            answers_due.push_back(apply_request(req.operation, req.value));
      end
      mismatches <= miss_count;
      awaiting   <= answers_due.size();
   end

endmodule

/* verif/tb_top.sv */
// Testbench top for the sorted set: clock, reset, request stimulus and verdict
module tb_top;
   import ssiq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY      = 64;
   localparam int PHASE_ITEMS   = 400;
   localparam int STRESS_CYCLES = 80;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 500000;

   // operation code that the block answers but otherwise ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

   logic clock = 1'b0;
   logic reset;

   ssiq_req_if req_if ();
   ssiq_rsp_if rsp_if ();

   int mismatches;
   int awaiting;

   // pacing knobs: percentage of cycles in which each side rests
   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit stress_go     = 1'b0;
   int sent          = 0;
   int cycle_count   = 0;

   // values inserted since the last clear, used to aim duplicates and hits
   logic signed [VALUE_W-1:0] pool[$];

   sorted_set_insert_query #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_if),
      .rsp_channel (rsp_if)
   );

   ssiq_checker #(
      .CAPACITY (CAPACITY)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: stall at random, and once hold off for a long stretch so that
   // the response register fills and the block stops taking requests
   initial begin : response_drain
      int held;
      held = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stress_go && held < STRESS_CYCLES) begin
            rsp_if.ready <= 1'b0;
            held++;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Mix of uniform words, a narrow band round zero (to force collisions)
   // and the extremes of the signed range, minus one and zero
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return VALUE_W'($urandom_range(40)) - 32'd20;
         1: begin
            case ($urandom_range(3))
               0:       return VAL_MIN;
               1:       return VAL_MAX;
               2:       return -32'sd1;
               default: return '0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Offer one request and hold it until accepted; ready is sampled at the
   // falling edge, where it is settled for the next rising edge
   task automatic offer(input logic [1:0] op, input logic signed [VALUE_W-1:0] val);
      bit taken;
      taken = 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.value     <= val;
      while (!taken) begin
         @(negedge clock);
         taken = req_if.ready;
         @(posedge clock);
      end
      sent++;
   endtask

   // One episode: clear, then random inserts, duplicates, lookups, unused codes
   // and clears; a fill episode pushes the set past its capacity
   task automatic run_episode(input bit fill_up, input bit fresh_only);
      int                        length;
      int                        k;
      int                        pick;
      logic signed [VALUE_W-1:0] v;
      pool.delete();
      offer(OP_CLEAR, pick_value());
      if (fill_up)
         length = 110;
      else
         length = $urandom_range(4, 30);
      for (k = 0; k < length; k++) begin
         pick = $urandom_range(99);
         if (fresh_only || pick < (fill_up ? 85 : 50)) begin
            v = pick_value();
            pool.push_back(v);
            offer(OP_INSERT, v);
         end else if (pick < 90 && pool.size() > 0 && pick % 3 == 0) begin
            offer(OP_INSERT, pool[$urandom_range(pool.size() - 1)]);
         end else if (pick < 90 && pool.size() > 0) begin
            offer(OP_QUERY, pool[$urandom_range(pool.size() - 1)]);
         end else if (pick < 95) begin
            offer(OP_QUERY, pick_value());
         end else if (pick < 98) begin
            offer(OP_UNUSED, pick_value());
         end else begin
            // drop the set in the middle of a run
            pool.delete();
            offer(OP_CLEAR, pick_value());
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      int phase_end;
      bit first;
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_CLEAR;
      req_if.value     <= '0;
      reset            <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty set, extremes, value below the head, duplicates,
      // hits and misses, the unused code and a clear
      offer(OP_QUERY,  '0);
      offer(OP_INSERT, '0);
      offer(OP_INSERT, VAL_MAX);
      offer(OP_INSERT, VAL_MIN);
      offer(OP_INSERT, -32'sd1);
      offer(OP_INSERT, '0);
      offer(OP_INSERT, VAL_MIN);
      offer(OP_QUERY,  VAL_MIN);
      offer(OP_QUERY,  VAL_MAX);
      offer(OP_QUERY,  32'sd1);
      offer(OP_UNUSED, VAL_MAX);
      offer(OP_QUERY,  -32'sd1);
      offer(OP_INSERT, 32'sd5);
      offer(OP_INSERT, 32'sd3);
      offer(OP_INSERT, 32'hAAAA_AAAA);
      offer(OP_INSERT, 32'h5555_5555);
      offer(OP_QUERY,  32'hAAAA_AAAA);
      offer(OP_UNUSED, '0);
      offer(OP_CLEAR,  32'hFFFF_FFFF);
      offer(OP_QUERY,  '0);
      offer(OP_INSERT, 32'sd7);
      offer(OP_CLEAR,  '0);

      // Random phases: no idling, sender idle, receiver stalling, both
      first = 1'b1;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
            1:       begin send_idle_pct = 57; stall_pct <= 0;  end
            2:       begin send_idle_pct = 0;  stall_pct <= 57; end
            default: begin send_idle_pct = 36; stall_pct <= 36; end
         endcase
         if (phase == 0)
            stress_go <= 1'b1;
         phase_end = sent + PHASE_ITEMS;
         while (sent < phase_end) begin
            if (first)
               run_episode(1'b1, 1'b1);
            else
               run_episode($urandom_range(5) == 0, 1'b0);
            first = 1'b0;
         end
      end
      req_if.valid <= 1'b0;

      // Drain: wait for the last responses, then settle before the verdict
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaiting == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/ssiq_pkg.sv
rtl/ssiq_req_if.sv
rtl/ssiq_rsp_if.sv
rtl/ssiq_cell.sv
rtl/sorted_set_insert_query.sv
verif/ssiq_checker.sv
verif/tb_top.sv
